/* design/acpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acpc_pkg: shared types and functions for the AES CBC page cipher
// S-box, inverse S-box, round functions and the queue entry type.
// ----------------------------------------------------------------------------
package acpc_pkg;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_IV    = 2'd1,
		ST_DATA  = 2'd2,
		ST_OUT   = 2'd3
	} eng_state_t;

	typedef struct packed {
		logic         opcode;
		logic         first_of_page;
		logic [63:0]  page_number;
		logic [127:0] data;
	} job_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] r;
		case (v)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r=8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r = r ^ x;
			x = xt(x);
		end
		return r;
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] v);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (sbox(i[7:0]) == v)
				r = i[7:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127-8*i -: 8];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last,
		input logic [127:0] rk);
		logic [7:0] t [16];
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3, al;
		for (int i = 0; i < 16; i++)
			t[i] = sbox(byte_at(s, (i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)));
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++)
			o[127-8*i -: 8] = t[i];
		return o ^ rk;
	endfunction

	function automatic logic [127:0] dec_round(input logic [127:0] s, input logic last,
		input logic [127:0] rk);
		logic [7:0] t [16];
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		for (int i = 0; i < 16; i++)
			t[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)] = inv_sbox(byte_at(s, i));
		for (int i = 0; i < 16; i++)
			t[i] = t[i] ^ byte_at(rk, i);
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				t[4*c]   = gf_mul(a0,8'd14)^gf_mul(a1,8'd11)^gf_mul(a2,8'd13)^gf_mul(a3,8'd9);
				t[4*c+1] = gf_mul(a0,8'd9)^gf_mul(a1,8'd14)^gf_mul(a2,8'd11)^gf_mul(a3,8'd13);
				t[4*c+2] = gf_mul(a0,8'd13)^gf_mul(a1,8'd9)^gf_mul(a2,8'd14)^gf_mul(a3,8'd11);
				t[4*c+3] = gf_mul(a0,8'd11)^gf_mul(a1,8'd13)^gf_mul(a2,8'd9)^gf_mul(a3,8'd14);
			end
		end
		for (int i = 0; i < 16; i++)
			o[127-8*i -: 8] = t[i];
		return o;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage
`default_nettype wire

/* design/acpc_keysched.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acpc_keysched: key expansion sequencer
// Expands the key one 32-bit word a cycle into a round key memory.
// ----------------------------------------------------------------------------
module acpc_keysched #(
	parameter int KEY_BITS = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [255:0] key,
	output logic              done,
	input  wire logic [3:0]   rd_round,
	output logic [127:0]      rd_key
);
	localparam int NK     = (KEY_BITS >= 256) ? 8 : ((KEY_BITS >= 192) ? 6 : 4);
	localparam int NR     = NK + 6;
	localparam int TOTAL  = 4 * (NR + 1);
	localparam int WIDX_W = $clog2(TOTAL + 1);

	logic [31:0]       win_q [8];
	logic [127:0]      mem_q [NR + 1];
	logic [WIDX_W-1:0] idx_q;
	logic [2:0]        mod_q;
	logic [7:0]        rcon_q;
	logic              busy_q;
	logic [127:0]      row_q;
	logic [31:0]       t;
	logic [31:0]       nw;

	always_comb begin
		t = win_q[NK-1];
		if (mod_q == 3'd0)
			t = acpc_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
		else if (NK > 6 && mod_q == 3'd4)
			t = acpc_pkg::sub_word(t);
		nw = win_q[0] ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= WIDX_W'(NK);
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			if (idx_q == WIDX_W'(TOTAL - 1))
				busy_q <= 1'b0;
			idx_q  <= idx_q + 1'b1;
			mod_q  <= (mod_q == 3'(NK - 1)) ? 3'd0 : mod_q + 1'b1;
			if (mod_q == 3'd0)
				rcon_q <= acpc_pkg::xt(rcon_q);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++)
				win_q[i] <= (i < NK) ? key[255-32*i -: 32] : 32'h0;
			for (int r = 0; r < NK / 4; r++)
				mem_q[r] <= key[255-128*r -: 128];
			if (NK == 6)
				row_q <= {64'h0, key[127:64]};
		end else if (busy_q) begin
			for (int i = 0; i < NK - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[NK-1] <= nw;
			row_q <= {row_q[95:0], nw};
			if (idx_q[1:0] == 2'd3)
				mem_q[idx_q[WIDX_W-1:2]] <= {row_q[95:0], nw};
		end
	end

	assign done   = !busy_q && !start;
	assign rd_key = mem_q[rd_round];
endmodule
`default_nettype wire

/* design/acpc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acpc_front: input stage and job queue
// Accepts transactions and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module acpc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire acpc_pkg::job_t in_job,
	output logic               job_valid,
	input  wire logic          job_take,
	output acpc_pkg::job_t     job
);
	acpc_pkg::job_t fifo_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;

	assign in_ready  = cnt_q != 2'd2;
	assign job_valid = cnt_q != 2'd0;
	assign job       = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready)
				wr_q <= !wr_q;
			if (job_take && job_valid)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(job_take && job_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			fifo_q[wr_q] <= in_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !job_valid) else $error("empty queue shows a job");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(job_take && job_valid)) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count lost a write");
endmodule
`default_nettype wire

/* design/acpc_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acpc_engine: round-iterative AES CBC engine
// Derives the page IV, runs one round a cycle, chains and registers results.
// ----------------------------------------------------------------------------
module acpc_engine #(
	parameter int KEY_BITS = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_take,
	input  wire acpc_pkg::job_t job,
	input  wire logic [255:0]  key,
	output logic [127:0]       res_data,
	output logic               res_valid,
	input  wire logic          res_ready
);
	localparam int NK = (KEY_BITS >= 256) ? 8 : ((KEY_BITS >= 192) ? 6 : 4);
	localparam int NR = NK + 6;

	acpc_pkg::eng_state_t state_q, state_d;
	acpc_pkg::job_t       job_q;
	logic [127:0]         chain_q;
	logic [127:0]         blk_q;
	logic [3:0]           rnd_q;
	logic                 ks_start;
	logic                 ks_done;
	logic                 ks_go_q;
	logic [3:0]           rd_round;
	logic [127:0]         rk;
	logic                 dec;
	logic                 last;
	logic [127:0]         nxt;
	logic [127:0]         src;
	logic                 res_valid_q;
	logic [127:0]         res_q;

	acpc_keysched #(.KEY_BITS(KEY_BITS)) u_ks (
		.clk(clk), .arst_n(arst_n), .start(ks_start), .key(key),
		.done(ks_done), .rd_round(rd_round), .rd_key(rk)
	);

	assign dec      = (state_q == acpc_pkg::ST_DATA) && (job_q.opcode == acpc_pkg::OP_DECRYPT);
	assign last     = rnd_q == 4'(NR);
	assign rd_round = dec ? 4'(NR) - rnd_q : rnd_q;
	assign nxt      = dec ? acpc_pkg::dec_round(blk_q, last, rk)
	                      : acpc_pkg::enc_round(blk_q, last, rk);
	assign src      = (job_q.opcode == acpc_pkg::OP_DECRYPT) ? job_q.data : job_q.data ^ chain_q;

	always_comb begin
		state_d  = state_q;
		job_take = 1'b0;
		ks_start = 1'b0;
		case (state_q)
			acpc_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					ks_start = 1'b1;
					state_d  = acpc_pkg::ST_OUT;
				end
			end
			acpc_pkg::ST_OUT: begin
				if (ks_done && (!res_valid_q || res_ready))
					state_d = job_q.first_of_page ? acpc_pkg::ST_IV : acpc_pkg::ST_DATA;
			end
			acpc_pkg::ST_IV: begin
				if (last)
					state_d = acpc_pkg::ST_DATA;
			end
			acpc_pkg::ST_DATA: begin
				if (last)
					state_d = acpc_pkg::ST_IDLE;
			end
			default: state_d = acpc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acpc_pkg::ST_IDLE;
			chain_q     <= '0;
			res_valid_q <= 1'b0;
			rnd_q       <= '0;
			ks_go_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			ks_go_q <= ks_start;
			if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				acpc_pkg::ST_OUT: rnd_q <= '0;
				acpc_pkg::ST_IV: begin
					rnd_q <= last ? 4'd0 : rnd_q + 1'b1;
					if (last)
						chain_q <= nxt;
				end
				acpc_pkg::ST_DATA: begin
					rnd_q <= last ? 4'd0 : rnd_q + 1'b1;
					if (last) begin
						res_valid_q <= 1'b1;
						chain_q     <= dec ? job_q.data : nxt;
					end
				end
				default: rnd_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take)
			job_q <= job;
		if (state_q == acpc_pkg::ST_OUT)
			blk_q <= job_q.first_of_page ? {job_q.page_number, ~job_q.page_number} : src;
		else if (state_q == acpc_pkg::ST_IV && last)
			blk_q <= (job_q.opcode == acpc_pkg::OP_DECRYPT) ? job_q.data : job_q.data ^ nxt;
		else if (rnd_q == 4'd0 && !dec)
			blk_q <= blk_q ^ rk;
		else if (rnd_q == 4'd0)
			blk_q <= blk_q ^ rk;
		else
			blk_q <= nxt;
		if (state_q == acpc_pkg::ST_DATA && last)
			res_q <= dec ? nxt ^ chain_q : nxt;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		ks_go_q |-> state_q == acpc_pkg::ST_OUT) else $error("key expansion out of step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acpc_pkg::ST_DATA && last) |-> (!res_valid_q || res_ready))
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= 4'(NR)) else $error("round count overrun");
endmodule
`default_nettype wire

/* design/aes_cbc_page_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cbc_page_cipher: AES CBC block cipher with page-number IV
// Usage: load the key over APB (key_word0..3 at 0x00..0x18), then stream
// blocks on s_axis. tdata = {data_lo, data_hi, page_number}, opcode
// in tuser[0], first_of_page in tuser[1]. Results leave on m_axis as {out_lo, out_hi}.
// Each transaction re-expands the key (one word a cycle), then runs NR+1
// round steps on the single round unit; a page start adds NR+1 more steps
// for the IV. The engine takes a new block only once it has finished the
// previous one; the round unit and the key sequencer set that pace. A
// two-entry queue takes transactions while the engine works, and the result
// register frees the engine while m_axis is stalled; a stalled result holds
// the engine before its next block only.
// Reset clears the key registers, the chain value and all handshakes.
// ----------------------------------------------------------------------------
module aes_cbc_page_cipher #(
	parameter int KEY_BITS = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // page_number, data_hi, data_lo
	input  wire logic [1:0]   s_axis_tuser,  // opcode, first_of_page
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0]      m_axis_tdata   // out_hi, out_lo
);
	logic [63:0]    key_q [4];
	acpc_pkg::job_t in_job, job;
	logic           job_valid, job_take;
	logic [127:0]   res;

	assign pready = 1'b1;
	assign prdata = key_q[paddr[4:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[paddr[4:3]] <= pwdata;
		end
	end

	assign in_job.opcode        = s_axis_tuser[0];
	assign in_job.first_of_page = s_axis_tuser[1];
	assign in_job.page_number   = s_axis_tdata[63:0];
	assign in_job.data          = {s_axis_tdata[127:64], s_axis_tdata[191:128]};

	acpc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_job(in_job), .job_valid(job_valid), .job_take(job_take), .job(job)
	);

	acpc_engine #(.KEY_BITS(KEY_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_take(job_take), .job(job),
		.key({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.res_data(res), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
	);

	assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
`default_nettype wire
